// File: rtl/mrf_pkg.sv
// Shared constants, payload types and state codes of the multicast range filter.
package mrf_pkg;

   localparam int MAX_RANGES    = 16;
   localparam int REFCOUNT_BITS = 16;
   localparam int ADDR_W        = 48;
   localparam int GROUP_BIT_POS = 40;
   localparam int IDX_W         = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int TOTAL_W       = $clog2(MAX_RANGES + 1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANGES - 1);

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_FILTER = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [ADDR_W-1:0] range_low;
      logic [ADDR_W-1:0] range_high;
      logic [ADDR_W-1:0] dest_addr;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [4:0]  ranges_in_use;
      logic [31:0] bad_multicast_count;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        lower;
      logic [ADDR_W-1:0]        upper;
      logic [REFCOUNT_BITS-1:0] refcount;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic exact;
      logic in_range;
   } cmp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/multicast_range_filter_core.sv
// Multicast address range filter: range table, sequencer and result registers.
//
// Usage: present an item on req_data and raise start; it is taken at a rising
// edge where start is high and busy is low. func selects add range, remove
// range or filter dest_addr; the other fields are ignored by the chosen func.
// Every item gives exactly one result on rsp_data, shown for one cycle with
// rsp_valid high. The receiver cannot stall, so results are never held back.
// The sequencer walks the range table in RAM one entry a cycle through a single
// compare unit, then a drain state waits for the registered read and a finish
// state updates the table; busy drops in the cycle the result is shown, so a new
// item can be taken while that result is on the ports.
// csr_wr_data sets the promiscuous bit on a cycle with csr_wr_en high; write
// it only while the block is idle.
// Reset empties the table, clears the range and reject counters and the
// promiscuous bit; it needs no clearing pass.
module multicast_range_filter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mrf_pkg::req_type req_data,
   output logic             rsp_valid,
   output mrf_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);
   import mrf_pkg::*;

   state_type                state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     cmp_pend_ff, cmp_pend_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         found_idx_ff, found_idx_in;
   logic [REFCOUNT_BITS-1:0] found_cnt_ff, found_cnt_in;
   logic                     free_ff, free_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic                     hit_ff, hit_in;
   logic [MAX_RANGES-1:0]    valid_ff, valid_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;
   logic [31:0]              reject_ff, reject_in;
   logic                     prom_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   entry_type                ram_wr_data;
   logic [ENTRY_W-1:0]       ram_rd_data;
   entry_type                rd_entry;
   cmp_type                  cmp_res;
   logic                     entry_live;
   logic                     ok;
   logic [REFCOUNT_BITS-1:0] dec_cnt;

   mrf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RANGES),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(scan_idx_ff),
      .rd_data(ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   mrf_cmp u_cmp (
      .entry (rd_entry),
      .key   (req_ff),
      .result(cmp_res)
   );

   assign entry_live = valid_ff[cmp_idx_ff];
   assign dec_cnt    = found_cnt_ff - REFCOUNT_BITS'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      req_in       = req_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_pend_in  = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_cnt_in = found_cnt_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      hit_in       = hit_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      reject_in    = reject_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = found_idx_ff;
      ram_wr_data  = '{lower: req_ff.range_low, upper: req_ff.range_high,
                       refcount: found_cnt_ff};
      ok           = 1'b0;

      // Fold the entry read last cycle into the search results
      if (cmp_pend_ff) begin
         if (entry_live && cmp_res.exact && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = cmp_idx_ff;
            found_cnt_in = rd_entry.refcount;
         end
         if (!entry_live && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
         if (entry_live && cmp_res.in_range) begin
            hit_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               scan_idx_in = '0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               hit_in      = 1'b0;
            end
         end
         ST_SCAN: begin
            cmp_pend_in = 1'b1;
            cmp_idx_in  = scan_idx_ff;
            if (scan_idx_ff != LAST_IDX) begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            cmp_pend_in = 1'b0;
         end
         ST_FINISH: begin
            case (req_ff.func)
               FUNC_ADD: begin
                  if (found_ff) begin
                     ok        = 1'b1;
                     ram_wr_en = 1'b1;
                     if (found_cnt_ff != {REFCOUNT_BITS{1'b1}}) begin
                        ram_wr_data.refcount = found_cnt_ff + REFCOUNT_BITS'(1);
                     end
                  end else if (free_ff) begin
                     ok                   = 1'b1;
                     ram_wr_en            = 1'b1;
                     ram_wr_addr          = free_idx_ff;
                     ram_wr_data.refcount = REFCOUNT_BITS'(1);
                     valid_in[free_idx_ff] = 1'b1;
                     total_in             = total_ff + TOTAL_W'(1);
                  end
               end
               FUNC_REMOVE: begin
                  if (found_ff) begin
                     ok                   = 1'b1;
                     ram_wr_en            = 1'b1;
                     ram_wr_data.refcount = dec_cnt;
                     // Free the entry when its last reference goes
                     if (dec_cnt == '0) begin
                        valid_in[found_idx_ff] = 1'b0;
                        if (total_ff != '0) begin
                           total_in = total_ff - TOTAL_W'(1);
                        end
                     end
                  end
               end
               FUNC_FILTER: begin
                  if (prom_ff || !req_ff.dest_addr[GROUP_BIT_POS] ||
                      (req_ff.dest_addr == {ADDR_W{1'b1}}) || hit_ff) begin
                     ok = 1'b1;
                  end else begin
                     reject_in = reject_ff + 32'd1;
                  end
               end
               default: ok = 1'b0;
            endcase
            rsp_valid_in               = 1'b1;
            rsp_in.ok                  = ok;
            rsp_in.ranges_in_use       = 5'(total_in);
            rsp_in.bad_multicast_count = reject_in;
         end
         default: cmp_pend_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_pend_ff  <= 1'b0;
         valid_ff     <= '0;
         total_ff     <= '0;
         reject_ff    <= '0;
         prom_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_pend_ff  <= cmp_pend_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         hit_ff       <= hit_in;
         if (csr_wr_en) begin
            prom_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_idx_ff <= found_idx_in;
      found_cnt_ff <= found_cnt_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/mrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mrf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mrf_cmp.sv
// Shared compare unit: exact bound match and inclusive range test for one entry.
module mrf_cmp (
   input  mrf_pkg::entry_type entry,
   input  mrf_pkg::req_type   key,
   output mrf_pkg::cmp_type   result
);
   import mrf_pkg::*;

   always_comb begin
      result.exact    = (entry.lower == key.range_low) && (entry.upper == key.range_high);
      result.in_range = (key.dest_addr >= entry.lower) && (key.dest_addr <= entry.upper);
   end

endmodule
